>>> src/chm_pkg.sv
// Shared types and constants for the chained hash map engine.
package chm_pkg;

    localparam int MAX_ORDER    = 10;
    localparam int POOL_ENTRIES = 256;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int ORD_W        = 4;
    localparam int BKT_W        = MAX_ORDER;
    localparam int BKT_SLOTS    = 1 << MAX_ORDER;
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int PTR_W        = IDX_W + 1;
    localparam int TOTAL_W      = 9;
    localparam int IN_TDATA_W   = 104;
    localparam int OUT_TDATA_W  = 48;

    localparam logic [PTR_W-1:0] NULL_LINK = PTR_W'(POOL_ENTRIES);

    // Request opcodes
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_RST_SWEEP,
        S_IDLE,
        S_HREAD,
        S_HEAD,
        S_CHK,
        S_CMP,
        S_PUT1,
        S_PUT2,
        S_REM1,
        S_REM2,
        S_CLR_SWEEP,
        S_RESP
    } chm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       init_write;
        logic       load_head;
        logic       cmp_step;
        logic       rd_free;
        logic       do_put;
        logic       rem_link;
        logic       rem_free;
        logic       set_st;
        logic [1:0] st_code;
        logic       load_out;
    } chm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       in_is_clear;
        logic [1:0] op;
        logic       init_last;
        logic       cur_end;
        logic       key_match;
        logic       free_null;
        logic       out_free;
    } chm_stat_t;

endpackage

>>> src/chained_hash_map_engine_core.sv
// Top level of the chained hash map engine.
// Key-value map with 1024 bucket heads and a pool of 256 chained entries.
// Requests are handled one at a time. After the input transfer the bucket head
// is read and loaded, then each chain entry visited is checked and compared
// (one registered read of key, value and link per entry) before the result
// moves into the output register. A miss adds one more check at the chain end,
// put adds a free-list read and an insert, remove adds relink and free steps.
// A stalled result register holds the request in its last state. After reset,
// and on every clear request, a sweep of all 1024 bucket heads empties them and
// rebuilds the free list; no request is taken during the sweep after reset.
// bucket_order may be written only while no request is in flight.
module chained_hash_map_engine_core
    import chm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [ORD_W-1:0]       cfg_wr_data,   // bucket_order
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // opcode, key, key_hash, new_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, found_value, entry_total
);

    chm_cmd_t  cmd;
    chm_stat_t stat;

    chm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    chm_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> src/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/chm_ctrl.sv
// Sequencer for sweep, chain walk, insert, unlink and result hand-off.
module chm_ctrl
    import chm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  chm_stat_t stat,
    output chm_cmd_t  cmd
);

    chm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_RST_SWEEP:
            begin
                cmd.init_write = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = stat.out_free;
                if (s_axis_tvalid && stat.out_free)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = stat.in_is_clear ? S_CLR_SWEEP : S_HREAD;
                end
            end
            S_HREAD: state_next = S_HEAD;
            S_HEAD:
            begin
                cmd.load_head = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                if (stat.cur_end)
                begin
                    cmd.set_st = 1'b1;
                    if (stat.op == OP_PUT)
                    begin
                        if (stat.free_null)
                        begin
                            cmd.st_code = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            cmd.st_code = ST_OK;
                            state_next  = S_PUT1;
                        end
                    end
                    else
                    begin
                        cmd.st_code = ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (stat.key_match)
                begin
                    cmd.set_st = 1'b1;
                    case (stat.op)
                        OP_PUT:
                        begin
                            cmd.st_code = ST_PRESENT;
                            state_next  = S_RESP;
                        end
                        OP_REMOVE:
                        begin
                            cmd.st_code = ST_OK;
                            state_next  = S_REM1;
                        end
                        default:
                        begin
                            cmd.st_code = ST_OK;
                            state_next  = S_RESP;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_PUT1:
            begin
                cmd.rd_free = 1'b1;
                state_next  = S_PUT2;
            end
            S_PUT2:
            begin
                cmd.rd_free = 1'b1;
                cmd.do_put  = 1'b1;
                state_next  = S_RESP;
            end
            S_REM1:
            begin
                cmd.rem_link = 1'b1;
                state_next   = S_REM2;
            end
            S_REM2:
            begin
                cmd.rem_free = 1'b1;
                state_next   = S_RESP;
            end
            S_CLR_SWEEP:
            begin
                cmd.init_write = 1'b1;
                cmd.set_st     = 1'b1;
                cmd.st_code    = ST_OK;
                if (stat.init_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_RST_SWEEP;
        endcase
    end

endmodule

>>> src/chm_datapath.sv
// Request registers, map memories, chain pointers and result register.
module chm_datapath
    import chm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   cfg_wr_en,
    input  logic [ORD_W-1:0]       cfg_wr_data,
    input  logic                   m_axis_tready,
    output logic                   m_axis_tvalid,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  chm_cmd_t               cmd,
    output chm_stat_t              stat
);

    logic [ORD_W-1:0]   order_reg;
    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [BKT_W-1:0]   bucket_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [PTR_W-1:0]   cur_reg, prev_reg, head_reg, next_reg, free_reg;
    logic [PTR_W-1:0]   steps_reg;
    logic [TOTAL_W-1:0] count_reg;
    logic [VAL_W-1:0]   found_reg;
    logic [1:0]         st_reg;
    logic [BKT_W-1:0]   sweep_reg;
    logic               out_valid_reg;
    logic [1:0]         out_st_reg;
    logic [VAL_W-1:0]   out_found_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic [ORD_W-1:0]   ord;
    logic [BKT_W:0]     mask;
    logic [BKT_W-1:0]   in_bucket;
    logic [1:0]         in_op;

    logic               head_we, link_we;
    logic [BKT_W-1:0]   head_waddr;
    logic [PTR_W-1:0]   head_wdata, head_rdata;
    logic [IDX_W-1:0]   link_waddr, link_raddr;
    logic [PTR_W-1:0]   link_wdata, link_rdata;
    logic [KEY_W-1:0]   key_rdata;
    logic [VAL_W-1:0]   val_rdata;
    logic               prev_null, sweep_in_pool;

    // Bucket index from the hash, order clamped to the table size
    assign ord       = (order_reg > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order_reg;
    assign mask      = ((BKT_W+1)'(1) << ord) - (BKT_W+1)'(1);
    assign in_bucket = s_axis_tdata[34 +: BKT_W] & mask[BKT_W-1:0];
    assign in_op     = s_axis_tdata[1:0];

    assign prev_null     = prev_reg[IDX_W];
    assign sweep_in_pool = (sweep_reg < BKT_W'(POOL_ENTRIES));

    // Bucket head write port
    always_comb
    begin
        head_we    = cmd.init_write || cmd.do_put || (cmd.rem_link && prev_null);
        head_waddr = cmd.init_write ? sweep_reg : bucket_reg;
        if (cmd.init_write)
        begin
            head_wdata = NULL_LINK;
        end
        else if (cmd.do_put)
        begin
            head_wdata = free_reg;
        end
        else
        begin
            head_wdata = next_reg;
        end
    end

    // Link write and read ports
    always_comb
    begin
        link_we = (cmd.init_write && sweep_in_pool) || cmd.do_put ||
                  (cmd.rem_link && !prev_null) || cmd.rem_free;
        if (cmd.init_write)
        begin
            link_waddr = sweep_reg[IDX_W-1:0];
            link_wdata = {1'b0, sweep_reg[IDX_W-1:0]} + PTR_W'(1);
        end
        else if (cmd.do_put)
        begin
            link_waddr = free_reg[IDX_W-1:0];
            link_wdata = head_reg;
        end
        else if (cmd.rem_link)
        begin
            link_waddr = prev_reg[IDX_W-1:0];
            link_wdata = next_reg;
        end
        else
        begin
            link_waddr = cur_reg[IDX_W-1:0];
            link_wdata = free_reg;
        end
        link_raddr = cmd.rd_free ? free_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    end

    chm_ram #(.WIDTH(PTR_W), .DEPTH(BKT_SLOTS)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (bucket_reg),
        .rdata (head_rdata)
    );

    chm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_keys (
        .clk   (clk),
        .we    (cmd.do_put),
        .waddr (free_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .raddr (cur_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    chm_ram #(.WIDTH(VAL_W), .DEPTH(POOL_ENTRIES)) u_vals (
        .clk   (clk),
        .we    (cmd.do_put),
        .waddr (free_reg[IDX_W-1:0]),
        .wdata (val_reg),
        .raddr (cur_reg[IDX_W-1:0]),
        .rdata (val_rdata)
    );

    // Control registers: order, free list head, count, sweep, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= ORD_W'(4);
            free_reg      <= '0;
            count_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                order_reg <= cfg_wr_data;
            end
            if (cmd.init_write)
            begin
                sweep_reg <= sweep_reg + BKT_W'(1);
                free_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.do_put)
            begin
                free_reg  <= link_rdata;
                count_reg <= count_reg + TOTAL_W'(1);
            end
            else if (cmd.rem_free)
            begin
                free_reg <= cur_reg;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - TOTAL_W'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request, walk and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg     <= in_op;
            key_reg    <= s_axis_tdata[2 +: KEY_W];
            bucket_reg <= in_bucket;
            val_reg    <= s_axis_tdata[66 +: VAL_W];
        end
        if (cmd.load_head)
        begin
            cur_reg   <= head_rdata;
            head_reg  <= head_rdata;
            prev_reg  <= NULL_LINK;
            steps_reg <= '0;
        end
        if (cmd.cmp_step)
        begin
            if (key_rdata == key_reg)
            begin
                found_reg <= val_rdata;
                next_reg  <= link_rdata;
            end
            else
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= link_rdata;
                steps_reg <= steps_reg + PTR_W'(1);
            end
        end
        if (cmd.set_st)
        begin
            st_reg <= cmd.st_code;
        end
        if (cmd.load_out)
        begin
            out_st_reg    <= st_reg;
            out_total_reg <= count_reg;
            out_found_reg <= (st_reg == ST_OK && (op_reg == OP_GET || op_reg == OP_REMOVE))
                             ? found_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 - VAL_W - TOTAL_W){1'b0}},
                            out_total_reg, out_found_reg, out_st_reg};

    assign stat.in_is_clear = (in_op == OP_CLEAR);
    assign stat.op          = op_reg;
    assign stat.init_last   = (sweep_reg == {BKT_W{1'b1}});
    assign stat.cur_end     = cur_reg[IDX_W] || steps_reg[IDX_W];
    assign stat.key_match   = (key_rdata == key_reg);
    assign stat.free_null   = free_reg[IDX_W];
    assign stat.out_free    = !out_valid_reg || m_axis_tready;

endmodule

>>> src/chm_checker.sv
// Port-level checks for the chained hash map engine, bound to the top level.
module chm_checker
    import chm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Entry total never exceeds the pool
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[42:34] <= TOTAL_W'(POOL_ENTRIES)))
        else $error("entry total beyond pool size");

    // Pool full is reported only when every entry is in use
    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL)
        |-> (m_axis_tdata[42:34] == TOTAL_W'(POOL_ENTRIES)))
        else $error("pool full with free entries");

    // A returned value implies success
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[33:2] != '0) |-> (m_axis_tdata[1:0] == ST_OK))
        else $error("value returned on failed request");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // No input transfer while a stalled result occupies the output
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input taken while result stalled");

endmodule

bind chained_hash_map_engine_core chm_checker u_chm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
